// ===== design/sparse_array_edit_engine_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sparse array edit engine.
// ----------------------------------------------------------------------------
`ifndef SPARSE_ARRAY_EDIT_ENGINE_MACROS_SVH
`define SPARSE_ARRAY_EDIT_ENGINE_MACROS_SVH

// same-cycle implication, disabled during reset
`define SAE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define SAE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/sae_pkg.sv =====
// ----------------------------------------------------------------------------
// sae_pkg
// Sizes, codes, cell command type and index helpers for the edit engine.
// ----------------------------------------------------------------------------
package sae_pkg;

  localparam int CAPACITY      = 64;
  localparam int ELEMENT_WIDTH = 32;
  localparam int IDX_W         = $clog2(CAPACITY);
  localparam int CNT_W         = $clog2(CAPACITY + 1);
  localparam int NRM_W         = ((CNT_W > 8) ? CNT_W : 8) + 1;

  // stream packing
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_POS_LSB = ELEMENT_WIDTH;
  localparam int OUT_CNT_LSB = ELEMENT_WIDTH + IDX_W;
  localparam int OUT_TDATA_W = ((ELEMENT_WIDTH + IDX_W + CNT_W + 7) / 8) * 8;

  // operations
  localparam logic [3:0] OP_WRITE      = 4'd0;
  localparam logic [3:0] OP_COPY       = 4'd1;
  localparam logic [3:0] OP_INSERT_VAL = 4'd2;
  localparam logic [3:0] OP_INSERT_CPY = 4'd3;
  localparam logic [3:0] OP_ERASE      = 4'd4;
  localparam logic [3:0] OP_MINSIZE    = 4'd5;
  localparam logic [3:0] OP_RESIZE     = 4'd6;
  localparam logic [3:0] OP_MAXSIZE    = 4'd7;
  localparam logic [3:0] OP_CLEAR      = 4'd8;
  localparam logic [3:0] OP_READ       = 4'd9;

  // result status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SKIP  = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // cell commands
  localparam logic [2:0] CELL_NOP    = 3'd0;
  localparam logic [2:0] CELL_WRITE  = 3'd1;
  localparam logic [2:0] CELL_INSERT = 3'd2;
  localparam logic [2:0] CELL_ERASE  = 3'd3;
  localparam logic [2:0] CELL_FILL   = 3'd4;
  localparam logic [2:0] CELL_ROTATE = 3'd5;

  typedef struct packed {
    logic [2:0]               code;
    logic [CNT_W-1:0]         pos;
    logic [CNT_W-1:0]         lo;
    logic [CNT_W-1:0]         hi;
    logic [ELEMENT_WIDTH-1:0] data;
    logic [ELEMENT_WIDTH-1:0] head;
  } cell_cmd_t;

  typedef struct packed {
    logic             ok;
    logic [CNT_W-1:0] pos;
  } norm_t;

  // Wrap a negative index by the count, then range check:
  // pos < count for a reference, pos <= count for an insert point.
  function automatic norm_t norm_index(input logic signed [7:0] idx,
                                       input logic [CNT_W-1:0] count,
                                       input logic insert);
    logic signed [NRM_W-1:0] w;
    logic signed [NRM_W-1:0] n;
    norm_t r;
    w = {{(NRM_W-8){idx[7]}}, idx};
    n = {{(NRM_W-CNT_W){1'b0}}, count};
    if (w < 0) w = w + n;
    r.ok  = (w >= 0) && (insert ? (w <= n) : (w < n));
    r.pos = w[CNT_W-1:0];
    return r;
  endfunction

endpackage

// ===== design/sae_cell.sv =====
// ----------------------------------------------------------------------------
// sae_cell
// One element slot of the array; shifts, writes, fills and rotates on command.
// ----------------------------------------------------------------------------
module sae_cell (
  input  logic                              clk,
  input  logic [sae_pkg::IDX_W-1:0]         idx,
  input  sae_pkg::cell_cmd_t                cmd,
  input  logic [sae_pkg::ELEMENT_WIDTH-1:0] left,
  input  logic [sae_pkg::ELEMENT_WIDTH-1:0] right,
  output logic [sae_pkg::ELEMENT_WIDTH-1:0] value
);

  logic [sae_pkg::CNT_W-1:0] idx_c;
  logic [sae_pkg::CNT_W-1:0] idx_p1;

  assign idx_c  = sae_pkg::CNT_W'(idx);
  assign idx_p1 = idx_c + 1'b1;

  always_ff @(posedge clk) begin
    unique case (cmd.code)
      sae_pkg::CELL_NOP: begin
      end
      sae_pkg::CELL_WRITE: begin
        if (idx_c == cmd.pos) value <= cmd.data;
      end
      sae_pkg::CELL_INSERT: begin
        if (idx_c == cmd.pos) value <= cmd.data;
        else if (idx_c > cmd.pos) value <= left;
      end
      sae_pkg::CELL_ERASE: begin
        if (idx_c >= cmd.pos) value <= right;
      end
      sae_pkg::CELL_FILL: begin
        if (idx_c >= cmd.lo && idx_c < cmd.hi) value <= cmd.data;
      end
      sae_pkg::CELL_ROTATE: begin
        // live part of the row turns left by one, head wraps to the end
        if (idx_p1 == cmd.hi) value <= cmd.head;
        else if (idx_p1 < cmd.hi) value <= right;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/sparse_array_edit_engine.sv =====
// ----------------------------------------------------------------------------
// sparse_array_edit_engine
// Bounded array editor built as a row of element cells plus a count.
// ----------------------------------------------------------------------------
// One request is taken at a time. An edit is captured, then applied across
// the whole cell row in one step while the status result is loaded.
// A read out rotates the row left once per cycle while the output is free and
// cell 0 streams out, so after count turns the array is back in place; an
// empty array gives a single status result instead. A stalled output holds
// the engine in its apply or read step.
module sparse_array_edit_engine (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              default_fill_wr,
  input  logic [31:0]                       default_fill_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // source_index[7:0], target_index[15:8], target_at_end[16],
  // literal_value[48:17], use_fill[49]
  input  logic [sae_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // operation[3:0]
  input  logic [3:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // element_value[31:0], element_position[37:32], current_count[44:38]
  output logic [sae_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // status[1:0]
  output logic [1:0]                        m_axis_tuser,
  output logic                              m_axis_tlast
);

  localparam int EW = sae_pkg::ELEMENT_WIDTH;
  localparam int CW = sae_pkg::CNT_W;
  localparam int NW = sae_pkg::NRM_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0]        state;
  logic [CW-1:0]     count;
  logic [CW-1:0]     rd_pos;
  logic [31:0]       default_fill;

  logic [3:0]        op;
  logic signed [7:0] src;
  logic signed [7:0] dst;
  logic              at_end;
  logic [EW-1:0]     lit;
  logic              use_fill;

  logic [EW-1:0]     elem_q [sae_pkg::CAPACITY];
  sae_pkg::cell_cmd_t cell_cmd;
  sae_pkg::cell_cmd_t exec_cmd;

  sae_pkg::norm_t    n_src;
  sae_pkg::norm_t    n_dst;
  sae_pkg::norm_t    n_ins;
  logic [CW-1:0]     ins_pos;
  logic              ins_ok;
  logic [EW-1:0]     src_val;
  logic [EW-1:0]     fill_val;
  logic signed [NW-1:0] size_w;
  logic signed [NW-1:0] count_w;
  logic              size_over;
  logic [CW-1:0]     size_val;

  logic [1:0]        exec_st;
  logic [CW-1:0]     count_next;
  logic              go_read;
  logic              out_free;
  logic              rd_last;

  logic [EW-1:0]     out_value;
  logic [sae_pkg::IDX_W-1:0] out_pos;
  logic [CW-1:0]     out_count;

  assign s_axis_tready = (state == S_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign rd_last       = ((rd_pos + 1'b1) == count);

  // ---- cell row ----
  for (genvar g = 0; g < sae_pkg::CAPACITY; g++) begin : g_cell
    logic [EW-1:0] left_v;
    logic [EW-1:0] right_v;
    if (g == 0) begin : g_first
      assign left_v = elem_q[g];
    end else begin : g_mid_l
      assign left_v = elem_q[g-1];
    end
    if (g == sae_pkg::CAPACITY - 1) begin : g_last
      assign right_v = elem_q[g];
    end else begin : g_mid_r
      assign right_v = elem_q[g+1];
    end
    sae_cell u_cell (
      .clk   (clk),
      .idx   (sae_pkg::IDX_W'(g)),
      .cmd   (cell_cmd),
      .left  (left_v),
      .right (right_v),
      .value (elem_q[g])
    );
  end

  // ---- edit decode ----
  always_comb begin
    n_src     = sae_pkg::norm_index(src, count, 1'b0);
    n_dst     = sae_pkg::norm_index(dst, count, 1'b0);
    n_ins     = sae_pkg::norm_index(dst, count, 1'b1);
    ins_pos   = at_end ? count : n_ins.pos;
    ins_ok    = at_end || n_ins.ok;
    src_val   = elem_q[n_src.pos[sae_pkg::IDX_W-1:0]];
    fill_val  = use_fill ? lit : EW'(default_fill);
    size_w    = {{(NW-8){src[7]}}, src};
    count_w   = {{(NW-CW){1'b0}}, count};
    size_over = (size_w > NW'(sae_pkg::CAPACITY));
    size_val  = size_over ? CW'(sae_pkg::CAPACITY) : size_w[CW-1:0];

    exec_st       = sae_pkg::ST_OK;
    count_next    = count;
    go_read       = 1'b0;
    exec_cmd      = '0;
    exec_cmd.code = sae_pkg::CELL_NOP;
    exec_cmd.head = elem_q[0];

    unique case (op) inside
      sae_pkg::OP_WRITE: begin
        if (!n_dst.ok) exec_st = sae_pkg::ST_SKIP;
        else begin
          exec_cmd.code = sae_pkg::CELL_WRITE;
          exec_cmd.pos  = n_dst.pos;
          exec_cmd.data = lit;
        end
      end
      sae_pkg::OP_COPY: begin
        if (!n_src.ok || !n_dst.ok) exec_st = sae_pkg::ST_SKIP;
        else begin
          exec_cmd.code = sae_pkg::CELL_WRITE;
          exec_cmd.pos  = n_dst.pos;
          exec_cmd.data = src_val;
        end
      end
      sae_pkg::OP_INSERT_VAL, sae_pkg::OP_INSERT_CPY: begin
        if ((op == sae_pkg::OP_INSERT_CPY && !n_src.ok) || !ins_ok) begin
          exec_st = sae_pkg::ST_SKIP;
        end else if (count >= CW'(sae_pkg::CAPACITY)) begin
          exec_st = sae_pkg::ST_OVF;
        end else begin
          exec_cmd.code = sae_pkg::CELL_INSERT;
          exec_cmd.pos  = ins_pos;
          exec_cmd.data = (op == sae_pkg::OP_INSERT_CPY) ? src_val : lit;
          count_next    = count + 1'b1;
        end
      end
      sae_pkg::OP_ERASE: begin
        if (!n_src.ok) exec_st = sae_pkg::ST_SKIP;
        else begin
          exec_cmd.code = sae_pkg::CELL_ERASE;
          exec_cmd.pos  = n_src.pos;
          count_next    = count - 1'b1;
        end
      end
      sae_pkg::OP_MINSIZE, sae_pkg::OP_RESIZE: begin
        if (src[7]) exec_st = sae_pkg::ST_SKIP;
        else begin
          if (size_over) exec_st = sae_pkg::ST_OVF;
          if (op == sae_pkg::OP_RESIZE || count < size_val) begin
            exec_cmd.code = sae_pkg::CELL_FILL;
            exec_cmd.lo   = count;
            exec_cmd.hi   = size_val;
            exec_cmd.data = fill_val;
            count_next    = size_val;
          end
        end
      end
      sae_pkg::OP_MAXSIZE: begin
        if (src[7]) exec_st = sae_pkg::ST_SKIP;
        else if (count_w > size_w) count_next = size_w[CW-1:0];
      end
      sae_pkg::OP_CLEAR: begin
        count_next = '0;
      end
      sae_pkg::OP_READ: begin
        if (count == '0) exec_st = sae_pkg::ST_EMPTY;
        else go_read = 1'b1;
      end
      default: begin
        exec_st = sae_pkg::ST_SKIP;
      end
    endcase
  end

  // command actually driven into the row this cycle
  always_comb begin
    cell_cmd      = exec_cmd;
    cell_cmd.code = sae_pkg::CELL_NOP;
    if (state == S_EXEC && out_free) begin
      cell_cmd = exec_cmd;
    end else if (state == S_READ && out_free) begin
      cell_cmd.code = sae_pkg::CELL_ROTATE;
      cell_cmd.hi   = count;
    end
  end

  // ---- control ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      rd_pos       <= '0;
      default_fill <= '0;
    end else begin
      if (default_fill_wr) default_fill <= default_fill_data;
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) state <= S_EXEC;
        end
        S_EXEC: begin
          if (out_free) begin
            count  <= count_next;
            rd_pos <= '0;
            state  <= go_read ? S_READ : S_IDLE;
          end
        end
        S_READ: begin
          if (out_free) begin
            rd_pos <= rd_pos + 1'b1;
            if (rd_last) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op       <= s_axis_tuser;
      src      <= s_axis_tdata[7:0];
      dst      <= s_axis_tdata[15:8];
      at_end   <= s_axis_tdata[16];
      lit      <= EW'(s_axis_tdata[48:17]);
      use_fill <= s_axis_tdata[49];
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == S_EXEC && out_free && !go_read) ||
                 (state == S_READ && out_free)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC && out_free && !go_read) begin
      out_value    <= '0;
      out_pos      <= '0;
      m_axis_tlast <= 1'b1;
      m_axis_tuser <= exec_st;
      out_count    <= count_next;
    end else if (state == S_READ && out_free) begin
      out_value    <= elem_q[0];
      out_pos      <= rd_pos[sae_pkg::IDX_W-1:0];
      m_axis_tlast <= rd_last;
      m_axis_tuser <= sae_pkg::ST_OK;
      out_count    <= count;
    end
  end

  assign m_axis_tdata = sae_pkg::OUT_TDATA_W'({out_count, out_pos, 32'(out_value)});

endmodule

// ===== design/sae_checker.sv =====
// ----------------------------------------------------------------------------
// sae_checker
// Port-level checks for the sparse array edit engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "sparse_array_edit_engine_macros.svh"

module sae_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [sae_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]                      m_axis_tuser,
  input logic                            m_axis_tlast
);

  logic [sae_pkg::CNT_W-1:0] res_count;

  assign res_count = m_axis_tdata[sae_pkg::OUT_CNT_LSB +: sae_pkg::CNT_W];

  // one request in flight: a request just taken closes the input
  `SAE_ASSERT_NXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second request taken while busy")

  // stalled result holds
  `SAE_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

  // an empty-array read is a single closing result with nothing in it
  `SAE_ASSERT_IMP(a_empty_read, m_axis_tvalid && m_axis_tuser == sae_pkg::ST_EMPTY, m_axis_tlast && res_count == '0 && m_axis_tdata[sae_pkg::ELEMENT_WIDTH-1:0] == '0, "bad empty-read result")

  // count never passes capacity
  `SAE_ASSERT_IMP(a_count_cap, m_axis_tvalid, res_count <= sae_pkg::CNT_W'(sae_pkg::CAPACITY), "count above capacity")

endmodule

bind sparse_array_edit_engine sae_checker u_sae_checker (.*);

// ===== tb/sv/sparse_array_edit_engine_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_array_edit_engine_test
// Streams edit requests into the array edit engine. Each accepted request
// runs through a behavioral copy of the array. The copy predicts every
// status and read-out result, and those are checked in order against the
// output stream. Random gaps and stalls sit on both sides, and the default
// fill register is rewritten between request batches.
// ----------------------------------------------------------------------------
module sparse_array_edit_engine_test;

  localparam int          CLK_HALF     = 10;
  localparam int          RESET_CYCLES = 12;
  localparam int          LIMIT_CYCLES = 5_000_000;
  localparam int          BATCHES      = 15;
  localparam int          BATCH_REQS   = 20;
  localparam int          MAX_PRINTED  = 40;
  localparam logic [3:0]  OP_UNUSED_LO = 4'd10;
  localparam logic [3:0]  OP_UNUSED_HI = 4'd15;

  typedef struct {
    logic [3:0]         op;
    logic signed [7:0]  src;
    logic signed [7:0]  dst;
    logic               at_end;
    logic [31:0]        lit;
    logic               use_fill;
  } edit_req_t;

  typedef struct {
    logic [31:0] value;
    logic [5:0]  pos;
    logic        last;
    logic [1:0]  status;
    logic [6:0]  count;
  } elem_result_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             default_fill_wr = 1'b0;
  logic [31:0]                      default_fill_data = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [sae_pkg::IN_TDATA_W-1:0]   s_axis_tdata = '0;
  logic [3:0]                       s_axis_tuser = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [sae_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;
  logic [1:0]                       m_axis_tuser;
  logic                             m_axis_tlast;

  // behavioral copy of the array
  logic [31:0]   arr_model [sae_pkg::CAPACITY];
  int            arr_count;
  logic [31:0]   fill_reg;

  edit_req_t     edit_queue [$];
  elem_result_t  pending_results [$];
  edit_req_t     cur_req;
  elem_result_t  want_res;

  int unsigned   err_count;
  int unsigned   reqs_accepted;
  int unsigned   results_seen;
  int unsigned   fills_written;
  int unsigned   cycle_count;
  int            gap_left;
  int            stall_left;
  bit            calm;
  bit            busy;

  sparse_array_edit_engine u_dut (
    .clk               (clk),
    .rst               (rst),
    .default_fill_wr   (default_fill_wr),
    .default_fill_data (default_fill_data),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .s_axis_tdata      (s_axis_tdata),
    .s_axis_tuser      (s_axis_tuser),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tdata      (m_axis_tdata),
    .m_axis_tuser      (m_axis_tuser),
    .m_axis_tlast      (m_axis_tlast)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    if (err_count < MAX_PRINTED)
      $display("ERROR: %s got %h expected %h at result %0d", what, got, want, results_seen);
    err_count++;
  endtask

  // negative index counts from the end; insert points may equal the count
  function automatic bit wrap_index(input int idx, input bit ins, output int pos);
    int w;
    w = idx;
    if (w < 0) w += arr_count;
    pos = w;
    if (w < 0) return 1'b0;
    return ins ? (w <= arr_count) : (w < arr_count);
  endfunction

  task automatic post_result(input logic [31:0] value, input int pos, input bit last,
                             input logic [1:0] status);
    elem_result_t r;
    r.value  = value;
    r.pos    = 6'(pos);
    r.last   = last;
    r.status = status;
    r.count  = 7'(arr_count);
    pending_results = {pending_results, r};
  endtask

  task automatic apply_edit(input edit_req_t r);
    int          a, b, n, i;
    bit          ok_a, ok_b;
    logic [1:0]  st;
    logic [31:0] fill, v;
    st   = sae_pkg::ST_OK;
    a    = 0;
    b    = 0;
    fill = r.use_fill ? r.lit : fill_reg;
    case (r.op) inside
      sae_pkg::OP_WRITE: begin
        if (wrap_index(r.dst, 1'b0, b)) arr_model[b] = r.lit;
        else st = sae_pkg::ST_SKIP;
      end
      sae_pkg::OP_COPY: begin
        ok_a = wrap_index(r.src, 1'b0, a);
        ok_b = wrap_index(r.dst, 1'b0, b);
        if (ok_a && ok_b) arr_model[b] = arr_model[a];
        else st = sae_pkg::ST_SKIP;
      end
      sae_pkg::OP_INSERT_VAL, sae_pkg::OP_INSERT_CPY: begin
        ok_a = 1'b1;
        if (r.op == sae_pkg::OP_INSERT_CPY) ok_a = wrap_index(r.src, 1'b0, a);
        if (r.at_end) begin
          ok_b = 1'b1;
          b    = arr_count;
        end else begin
          ok_b = wrap_index(r.dst, 1'b1, b);
        end
        if (!ok_a || !ok_b) begin
          st = sae_pkg::ST_SKIP;
        end else if (arr_count >= sae_pkg::CAPACITY) begin
          st = sae_pkg::ST_OVF;
        end else begin
          v = (r.op == sae_pkg::OP_INSERT_CPY) ? arr_model[a] : r.lit;
          for (i = arr_count; i > b; i--) arr_model[i] = arr_model[i-1];
          arr_model[b] = v;
          arr_count++;
        end
      end
      sae_pkg::OP_ERASE: begin
        if (wrap_index(r.src, 1'b0, a)) begin
          for (i = a; i + 1 < arr_count; i++) arr_model[i] = arr_model[i+1];
          arr_count--;
        end else begin
          st = sae_pkg::ST_SKIP;
        end
      end
      sae_pkg::OP_MINSIZE, sae_pkg::OP_RESIZE: begin
        n = r.src;
        if (n < 0) begin
          st = sae_pkg::ST_SKIP;
        end else begin
          if (n > sae_pkg::CAPACITY) begin
            n  = sae_pkg::CAPACITY;
            st = sae_pkg::ST_OVF;
          end
          if (r.op == sae_pkg::OP_RESIZE || arr_count < n) begin
            for (i = arr_count; i < n; i++) arr_model[i] = fill;
            arr_count = n;
          end
        end
      end
      sae_pkg::OP_MAXSIZE: begin
        n = r.src;
        if (n < 0) st = sae_pkg::ST_SKIP;
        else if (arr_count > n) arr_count = n;
      end
      sae_pkg::OP_CLEAR: arr_count = 0;
      sae_pkg::OP_READ: begin
        if (arr_count == 0) post_result('0, 0, 1'b1, sae_pkg::ST_EMPTY);
        for (i = 0; i < arr_count; i++)
          post_result(arr_model[i], i, (i + 1 == arr_count), sae_pkg::ST_OK);
      end
      default: st = sae_pkg::ST_SKIP;
    endcase
    if (r.op != sae_pkg::OP_READ) post_result('0, 0, 1'b1, st);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // mostly valid positions, in both plain and end-relative form
  function automatic int pick_index(input int cnt, input bit ins);
    int r, lim, pos;
    lim = ins ? cnt + 1 : cnt;
    r   = $urandom_range(0, 9);
    if (r < 2 || lim == 0) return $urandom_range(0, 255);
    if (r == 2) return $urandom_range(0, 1) ? lim : -cnt - 1;
    pos = $urandom_range(0, lim - 1);
    return $urandom_range(0, 1) ? pos - cnt : pos;
  endfunction

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 24);
    if (r < 8) return $urandom_range(0, 80);
    if (r == 8) return $urandom_range(0, 255);
    return $urandom_range(sae_pkg::CAPACITY, sae_pkg::CAPACITY + 1);
  endfunction

  function automatic edit_req_t random_req(input int cnt);
    edit_req_t q;
    int r;
    r          = $urandom_range(0, 99);
    q.at_end   = $urandom_range(0, 1);
    q.use_fill = $urandom_range(0, 1);
    q.lit      = $urandom();
    if ($urandom_range(0, 15) == 0) q.lit = $urandom_range(0, 1) ? '1 : '0;
    q.src      = 8'(pick_index(cnt, 1'b0));
    q.dst      = 8'(pick_index(cnt, 1'b0));
    if      (r < 15) q.op = sae_pkg::OP_WRITE;
    else if (r < 25) q.op = sae_pkg::OP_COPY;
    else if (r < 42) q.op = sae_pkg::OP_INSERT_VAL;
    else if (r < 52) q.op = sae_pkg::OP_INSERT_CPY;
    else if (r < 62) q.op = sae_pkg::OP_ERASE;
    else if (r < 69) q.op = sae_pkg::OP_MINSIZE;
    else if (r < 76) q.op = sae_pkg::OP_RESIZE;
    else if (r < 81) q.op = sae_pkg::OP_MAXSIZE;
    else if (r < 84) q.op = sae_pkg::OP_CLEAR;
    else if (r < 96) q.op = sae_pkg::OP_READ;
    else             q.op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    if (q.op == sae_pkg::OP_INSERT_VAL || q.op == sae_pkg::OP_INSERT_CPY)
      q.dst = 8'(pick_index(cnt, 1'b1));
    if (q.op == sae_pkg::OP_MINSIZE || q.op == sae_pkg::OP_RESIZE ||
        q.op == sae_pkg::OP_MAXSIZE)
      q.src = 8'(pick_size());
    return q;
  endfunction

  task automatic add_req(input logic [3:0] op, input int src, input int dst,
                         input bit at_end, input logic [31:0] lit, input bit use_fill);
    edit_req_t q;
    q.op       = op;
    q.src      = 8'(src);
    q.dst      = 8'(dst);
    q.at_end   = at_end;
    q.lit      = lit;
    q.use_fill = use_fill;
    edit_queue = {edit_queue, q};
  endtask

  // nothing queued, nothing on the wire, nothing owed
  task automatic wait_idle(input int settle);
    @(negedge clk);
    while (edit_queue.size() != 0 || s_axis_tvalid || pending_results.size() != 0)
      @(negedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_fill(input logic [31:0] v);
    @(posedge clk);
    default_fill_wr   <= 1'b1;
    default_fill_data <= v;
    fill_reg = v;
    fills_written++;
    @(posedge clk);
    default_fill_wr   <= 1'b0;
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      busy = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        apply_edit(cur_req);
        reqs_accepted++;
        busy = 1'b0;
        gap_left = calm ? 0 : pick_gap();
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (edit_queue.size() > 0) begin
          cur_req = edit_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {6'b0, cur_req.use_fill, cur_req.lit, cur_req.at_end,
                            cur_req.dst, cur_req.src};
          s_axis_tuser  <= cur_req.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and output stalls
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report("result with nothing pending, value", m_axis_tdata[31:0], '0);
        end else begin
          want_res = pending_results.pop_front();
          if (m_axis_tdata[31:0] !== want_res.value)
            report("element_value", m_axis_tdata[31:0], want_res.value);
          if (m_axis_tdata[sae_pkg::OUT_POS_LSB +: 6] !== want_res.pos)
            report("element_position", 32'(m_axis_tdata[sae_pkg::OUT_POS_LSB +: 6]),
                   32'(want_res.pos));
          if (m_axis_tlast !== want_res.last)
            report("last_of_run", 32'(m_axis_tlast), 32'(want_res.last));
          if (m_axis_tuser !== want_res.status)
            report("status", 32'(m_axis_tuser), 32'(want_res.status));
          if (m_axis_tdata[sae_pkg::OUT_CNT_LSB +: 7] !== want_res.count)
            report("current_count", 32'(m_axis_tdata[sae_pkg::OUT_CNT_LSB +: 7]),
                   32'(want_res.count));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TIMEOUT after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int          b, k, g, n;
    edit_req_t   q;
    logic [31:0] fill_list [4];
    for (k = 0; k < sae_pkg::CAPACITY; k++) arr_model[k] = '0;
    arr_count = 0;
    fill_reg  = '0;
    calm      = 1'b0;
    fill_list[0] = 32'hFFFF_FFFF;
    fill_list[1] = 32'h0000_0000;
    fill_list[2] = 32'h8000_0001;
    fill_list[3] = $urandom();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    set_fill(32'h5A5A_C3C3);

    // directed: empty array, insert forms, wrapping, saturation, odd codes
    @(negedge clk);
    add_req(sae_pkg::OP_READ,        0,    0,  0, '0,            0);
    add_req(sae_pkg::OP_WRITE,       0,    0,  0, 32'h1111_1111, 0);
    add_req(sae_pkg::OP_ERASE,       0,    0,  0, '0,            0);
    add_req(sae_pkg::OP_INSERT_VAL,  0,    0,  1, 32'hFFFF_FFFF, 0);
    add_req(sae_pkg::OP_INSERT_VAL,  0,    0,  0, 32'h0000_0000, 0);
    add_req(sae_pkg::OP_INSERT_VAL,  0,   -1,  0, 32'h0000_1234, 0);
    add_req(sae_pkg::OP_INSERT_VAL,  0,    3,  0, 32'h8000_0000, 0);
    add_req(sae_pkg::OP_INSERT_VAL,  0,    5,  0, 32'hBAD0_0001, 0);
    add_req(sae_pkg::OP_INSERT_CPY, -1,    0,  0, '0,            0);
    add_req(sae_pkg::OP_INSERT_CPY,  9,    0,  1, '0,            0);
    add_req(sae_pkg::OP_COPY,        0,   -2,  0, '0,            0);
    add_req(sae_pkg::OP_WRITE,       0,   -5,  1, 32'hA5A5_A5A5, 1);
    add_req(sae_pkg::OP_WRITE,       0,   -6,  0, 32'h2222_2222, 0);
    add_req(sae_pkg::OP_READ,        0,    0,  0, '0,            0);
    add_req(sae_pkg::OP_ERASE,      -1,    0,  0, '0,            0);
    add_req(sae_pkg::OP_MINSIZE,     2,    0,  0, 32'h3333_3333, 1);
    add_req(sae_pkg::OP_MINSIZE,     6,    0,  0, 32'h0000_0077, 1);
    add_req(sae_pkg::OP_RESIZE,    127,    0,  0, '0,            0);
    add_req(sae_pkg::OP_INSERT_VAL,  0,    0,  1, 32'h4444_4444, 0);
    add_req(sae_pkg::OP_INSERT_CPY,  0,    0,  0, '0,            0);
    add_req(sae_pkg::OP_READ,        0,    0,  0, '0,            0);
    add_req(sae_pkg::OP_MAXSIZE,    -1,    0,  0, '0,            0);
    add_req(sae_pkg::OP_MAXSIZE,     3,    0,  0, '0,            0);
    add_req(sae_pkg::OP_RESIZE,   -128,    0,  0, '0,            0);
    add_req(OP_UNUSED_LO,            0,    0,  0, '0,            0);
    add_req(OP_UNUSED_HI,            0,    0,  0, '0,            0);
    add_req(sae_pkg::OP_CLEAR,       0,    0,  0, '0,            0);
    add_req(sae_pkg::OP_READ,        0,    0,  0, '0,            0);

    for (b = 0; b < BATCHES; b++) begin
      wait_idle(4);
      if (b % 2 == 0) set_fill(fill_list[(b / 2) % 4]);
      @(negedge clk);
      calm = (b % 4 == 3);
      g = arr_count;
      for (k = 0; k < BATCH_REQS; k++) begin
        q = random_req(g);
        edit_queue = {edit_queue, q};
        // rough running count so later indices tend to land in range
        n = q.src;
        case (q.op) inside
          sae_pkg::OP_INSERT_VAL, sae_pkg::OP_INSERT_CPY:
            if (g < sae_pkg::CAPACITY) g++;
          sae_pkg::OP_ERASE:   if (g > 0) g--;
          sae_pkg::OP_MINSIZE:
            if (n > g) g = (n > sae_pkg::CAPACITY) ? sae_pkg::CAPACITY : n;
          sae_pkg::OP_RESIZE:
            if (n >= 0) g = (n > sae_pkg::CAPACITY) ? sae_pkg::CAPACITY : n;
          sae_pkg::OP_MAXSIZE: if (n >= 0 && n < g) g = n;
          sae_pkg::OP_CLEAR:   g = 0;
          default: ;
        endcase
      end
    end
    wait_idle(10);

    $display("Covered %0d edit requests (directed and random), %0d results checked,",
             reqs_accepted, results_seen);
    $display("%0d default fill writes, output stalls and input gaps throughout", fills_written);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/sae_pkg.sv
design/sae_cell.sv
design/sparse_array_edit_engine.sv
design/sae_checker.sv
tb/sv/sparse_array_edit_engine_test.sv
